>>> rtl/core/tlbl_pkg.sv
`default_nettype none

package tlbl_pkg;

   localparam int ADDR_W     = 32;
   localparam int PID_W      = 8;
   localparam int TAG_W      = 28;
   localparam int SHIFT_W    = 5;
   localparam int ENTRIES_W  = 9;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [SHIFT_W-1:0] SHIFT_MIN = SHIFT_W'(4);
   localparam logic [SHIFT_W-1:0] SHIFT_MAX = SHIFT_W'(16);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POLICY_LRU     = CSR_IDX_W'(0),
      CSR_PAGE_SHIFT     = CSR_IDX_W'(1),
      CSR_ENTRIES_IN_USE = CSR_IDX_W'(2),
      CSR_PER_PROCESS    = CSR_IDX_W'(3)
   } tlbl_csr_type;

   typedef struct packed {
      logic                 policy_lru;
      logic [SHIFT_W-1:0]   page_shift;
      logic [ENTRIES_W-1:0] entries_in_use;
      logic                 per_process;
   } tlbl_cfg_type;

   typedef struct packed {
      logic [TAG_W-1:0] page;
      logic [PID_W-1:0] pid;
   } tlbl_item_type;

endpackage

`default_nettype wire

>>> rtl/core/tlbl_channels.sv
`default_nettype none

interface tlbl_req_if;
   import tlbl_pkg::*;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] address;
   logic [PID_W-1:0]  pid;
   modport source (output valid, output address, output pid, input ready);
   modport sink (input valid, input address, input pid, output ready);
endinterface

interface tlbl_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic evicted;
   modport source (output valid, output hit, output evicted, input ready);
   modport sink (input valid, input hit, input evicted, output ready);
endinterface

interface tlbl_csr_if;
   import tlbl_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/tlbl_front.sv
`default_nettype none

module tlbl_front (
   input  wire                     clock,
   input  wire                     reset,
   input  tlbl_pkg::tlbl_cfg_type  cfg,
   tlbl_req_if.sink                req,
   output logic                    q_valid,
   output tlbl_pkg::tlbl_item_type q_item,
   input  wire                     q_pop
);
   import tlbl_pkg::*;

   logic [SHIFT_W-1:0] shift;
   tlbl_item_type      new_item;
   tlbl_item_type      q_ff [2];
   logic               wp_ff;
   logic               rp_ff;
   logic [1:0]         cnt_ff;
   logic [1:0]         cnt_in;
   logic               push;
   logic               pop;
   logic [ADDR_W-1:0]  shifted;

   always_comb begin
      if (cfg.page_shift < SHIFT_MIN) begin
         shift = SHIFT_MIN;
      end else if (cfg.page_shift > SHIFT_MAX) begin
         shift = SHIFT_MAX;
      end else begin
         shift = cfg.page_shift;
      end
   end

   assign shifted       = req.address >> shift;
   assign new_item.page = shifted[TAG_W-1:0];
   assign new_item.pid  = req.pid;

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign pop       = q_pop && (cnt_ff != 2'd0);
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};

   assign q_valid = (cnt_ff != 2'd0);
   assign q_item  = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (pop) begin
            rp_ff <= ~rp_ff;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= new_item;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/tlbl_back.sv
`default_nettype none

module tlbl_back #(
   parameter int MAX_ENTRIES = 256,
   parameter int PID_BITS    = 8
) (
   input  wire                                clock,
   input  wire                                reset,
   input  tlbl_pkg::tlbl_cfg_type             cfg,
   input  wire                                q_valid,
   input  tlbl_pkg::tlbl_item_type            q_item,
   output logic                               q_pop,
   tlbl_rsp_if.source                         rsp,
   output logic [$clog2(MAX_ENTRIES):0]       occupancy
);
   import tlbl_pkg::*;

   localparam int IDX_W    = $clog2(MAX_ENTRIES);
   localparam int CNT_W    = IDX_W + 1;
   localparam int PID_KEEP = (PID_BITS < PID_W) ? PID_BITS : PID_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

   typedef struct packed {
      logic [TAG_W-1:0]    page;
      logic [PID_KEEP-1:0] pid;
      logic [IDX_W-1:0]    rank;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE,
      ST_RESULT
   } state_type;

   state_type            state_ff;
   entry_type            mem [MAX_ENTRIES];
   entry_type            rd_data_ff;
   logic                 rd_vld_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic                 issue_ff;
   logic [MAX_ENTRIES-1:0] valid_ff;
   logic [CNT_W-1:0]     occ_ff;
   tlbl_item_type        item_ff;
   logic [PID_KEEP-1:0]  item_pid;

   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     best_ff, best_in;
   logic [IDX_W-1:0]     fidx_ff, fidx_in;
   logic                 old_ff, old_in;
   logic [IDX_W-1:0]     oidx_ff, oidx_in;
   logic                 free_ff, free_in;
   logic [IDX_W-1:0]     fridx_ff, fridx_in;

   logic                 hit_ff;
   logic                 evict_ff;
   logic                 slot_ok_ff;
   logic [IDX_W-1:0]     slot_ff;
   logic                 rsp_vld_ff;
   logic                 rsp_hit_ff;
   logic                 rsp_evict_ff;

   logic [CNT_W-1:0]     cap;
   logic [CNT_W-1:0]     occ_m1;
   logic [IDX_W-1:0]     oldest;
   logic                 cur_v;
   logic                 match;
   logic                 evict_c;
   logic                 slot_ok_c;
   logic [IDX_W-1:0]     slot_c;
   logic                 rd_en;
   logic                 wr_en;
   entry_type            wr_data;

   always_comb begin
      if (cfg.entries_in_use == '0) begin
         cap = CNT_W'(1);
      end else if (cfg.entries_in_use > ENTRIES_W'(MAX_ENTRIES)) begin
         cap = CNT_W'(MAX_ENTRIES);
      end else begin
         cap = cfg.entries_in_use[CNT_W-1:0];
      end
   end

   assign occ_m1   = occ_ff - CNT_W'(1);
   assign oldest   = occ_m1[IDX_W-1:0];
   assign item_pid = item_ff.pid[PID_KEEP-1:0];
   assign cur_v    = valid_ff[rd_idx_ff];
   assign match    = cur_v && (rd_data_ff.page == item_ff.page)
                     && (!cfg.per_process || (rd_data_ff.pid == item_pid));

   always_comb begin
      found_in = found_ff;
      best_in  = best_ff;
      fidx_in  = fidx_ff;
      old_in   = old_ff;
      oidx_in  = oidx_ff;
      free_in  = free_ff;
      fridx_in = fridx_ff;
      if (match && (!found_ff || (rd_data_ff.rank < best_ff))) begin
         found_in = 1'b1;
         best_in  = rd_data_ff.rank;
         fidx_in  = rd_idx_ff;
      end
      if (cur_v && (rd_data_ff.rank == oldest) && !old_ff) begin
         old_in  = 1'b1;
         oidx_in = rd_idx_ff;
      end
      if (!cur_v && !free_ff) begin
         free_in  = 1'b1;
         fridx_in = rd_idx_ff;
      end
   end

   always_comb begin
      evict_c   = (occ_ff >= cap) && (occ_ff != '0) && old_in;
      slot_ok_c = 1'b0;
      slot_c    = fridx_in;
      if (evict_c && (!free_in || (oidx_in < fridx_in))) begin
         slot_ok_c = 1'b1;
         slot_c    = oidx_in;
      end else if (free_in) begin
         slot_ok_c = 1'b1;
      end
   end

   always_comb begin
      wr_en        = 1'b0;
      wr_data      = rd_data_ff;
      wr_data.rank = rd_data_ff.rank + IDX_W'(1);
      if ((state_ff == ST_UPDATE) && rd_vld_ff) begin
         if (hit_ff) begin
            if (rd_idx_ff == fidx_ff) begin
               wr_en        = 1'b1;
               wr_data.rank = '0;
            end else if (cur_v && (rd_data_ff.rank < best_ff)) begin
               wr_en = 1'b1;
            end
         end else begin
            if (slot_ok_ff && (rd_idx_ff == slot_ff)) begin
               wr_en        = 1'b1;
               wr_data.page = item_ff.page;
               wr_data.pid  = item_pid;
               wr_data.rank = '0;
            end else if (cur_v) begin
               wr_en = 1'b1;
            end
         end
      end
   end

   assign rd_en       = issue_ff;
   assign q_pop       = (state_ff == ST_IDLE) && q_valid;
   assign rsp.valid   = rsp_vld_ff;
   assign rsp.hit     = rsp_hit_ff;
   assign rsp.evicted = rsp_evict_ff;
   assign occupancy   = occ_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[rd_idx_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_vld_ff  <= 1'b0;
         issue_ff   <= 1'b0;
         valid_ff   <= '0;
         occ_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
         rd_idx_ff <= idx_ff;
         if (issue_ff) begin
            idx_ff <= idx_ff + IDX_W'(1);
            if (idx_ff == LAST_IDX) begin
               issue_ff <= 1'b0;
            end
         end
         if (rsp_vld_ff && rsp.ready && (state_ff != ST_RESULT)) begin
            rsp_vld_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  item_ff  <= q_item;
                  found_ff <= 1'b0;
                  old_ff   <= 1'b0;
                  free_ff  <= 1'b0;
                  idx_ff   <= '0;
                  issue_ff <= 1'b1;
                  state_ff <= ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               if (rd_vld_ff) begin
                  found_ff <= found_in;
                  best_ff  <= best_in;
                  fidx_ff  <= fidx_in;
                  old_ff   <= old_in;
                  oidx_ff  <= oidx_in;
                  free_ff  <= free_in;
                  fridx_ff <= fridx_in;
                  if (rd_idx_ff == LAST_IDX) begin
                     hit_ff     <= found_in;
                     evict_ff   <= !found_in && evict_c;
                     slot_ok_ff <= slot_ok_c;
                     slot_ff    <= slot_c;
                     if (found_in && !cfg.policy_lru) begin
                        state_ff <= ST_RESULT;
                     end else begin
                        if (!found_in) begin
                           valid_ff <= (valid_ff & ~(MAX_ENTRIES'(evict_c) << oidx_in))
                                       | (MAX_ENTRIES'(slot_ok_c) << slot_c);
                           occ_ff <= occ_ff + CNT_W'(slot_ok_c) - CNT_W'(evict_c);
                        end
                        idx_ff   <= '0;
                        issue_ff <= 1'b1;
                        state_ff <= ST_UPDATE;
                     end
                  end
               end
            end
            ST_UPDATE: begin
               if (rd_vld_ff && (rd_idx_ff == LAST_IDX)) begin
                  state_ff <= ST_RESULT;
               end
            end
            ST_RESULT: begin
               if (!rsp_vld_ff || rsp.ready) begin
                  rsp_vld_ff   <= 1'b1;
                  rsp_hit_ff   <= hit_ff;
                  rsp_evict_ff <= evict_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/tlb_lookup_with_replacement_core.sv
`default_nettype none

// Fully associative TLB with FIFO or LRU replacement. One reference (address, pid) goes in
// and one result (hit, evicted) comes out per reference, in order. A two-entry queue takes
// references while the lookup engine works, and a response register holds the last result
// until it is taken. The engine handles one reference at a time against an entry memory with
// one read port and one write port, one entry per cycle: a FIFO hit needs only a tag search
// pass, while a miss or an LRU hit needs a tag search pass and a rank update pass.
// Configuration writes are taken at any time, with csr ready always high, and are meant to
// change only while no reference is in flight.

module tlb_lookup_with_replacement_core #(
   parameter int MAX_ENTRIES = 256,
   parameter int PID_BITS    = 8
) (
   input  wire         clock,
   input  wire         reset,
   tlbl_req_if.sink    req_ch,
   tlbl_rsp_if.source  rsp_ch,
   tlbl_csr_if.sink    csr_ch
);
   import tlbl_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES) + 1;

   tlbl_cfg_type  cfg_ff;
   logic          q_valid;
   tlbl_item_type q_item;
   logic          q_pop;
   logic [CNT_W-1:0] occupancy;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.policy_lru     <= 1'b0;
         cfg_ff.page_shift     <= SHIFT_W'(12);
         cfg_ff.entries_in_use <= ENTRIES_W'(256);
         cfg_ff.per_process    <= 1'b1;
      end else if (csr_ch.valid) begin
         case (tlbl_csr_type'(csr_ch.index))
            CSR_POLICY_LRU:     cfg_ff.policy_lru     <= csr_ch.data[0];
            CSR_PAGE_SHIFT:     cfg_ff.page_shift     <= csr_ch.data[SHIFT_W-1:0];
            CSR_ENTRIES_IN_USE: cfg_ff.entries_in_use <= csr_ch.data[ENTRIES_W-1:0];
            CSR_PER_PROCESS:    cfg_ff.per_process    <= csr_ch.data[0];
            default: begin
            end
         endcase
      end
   end

   tlbl_front u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .req     (req_ch),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop)
   );

   tlbl_back #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .PID_BITS    (PID_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp       (rsp_ch),
      .occupancy (occupancy)
   );

`ifndef SYNTHESIS
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !(rsp_ch.hit && rsp_ch.evicted))
      else $error("hit and evicted both set");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy <= CNT_W'(MAX_ENTRIES))
      else $error("occupancy above entry count");

   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ((occupancy == $past(occupancy))
                         || (occupancy == $past(occupancy) + CNT_W'(1))))
      else $error("occupancy changed by more than one");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`default_nettype none

module tb;
   import tlbl_pkg::*;

   localparam int SLOTS            = 256;
   localparam int SETTLE_CYCLES    = 2 * SLOTS + 16;
   localparam int WATCHDOG_LIMIT   = 20000;
   localparam int HOLD_OFF_CYCLES  = 3000;
   localparam int HOLD_OFF_AT      = 40;
   localparam int RANDOM_PHASES    = 10;
   localparam int ITEMS_PER_PHASE  = 175;
   localparam int POOL_SIZE        = 400;
   localparam int MAX_REPORTS      = 40;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = '1;

   typedef struct packed {
      logic hit;
      logic evicted;
   } lookup_result_type;

   typedef struct {
      bit                    is_csr;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
      logic [ADDR_W-1:0]     address;
      logic [PID_W-1:0]      pid;
      bit                    typed;
      lookup_result_type     want;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tlbl_req_if req_ch ();
   tlbl_rsp_if rsp_ch ();
   tlbl_csr_if csr_ch ();

   tlb_lookup_with_replacement_core #(
      .MAX_ENTRIES (SLOTS),
      .PID_BITS    (PID_W)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // TLB shadow state
   logic [TAG_W-1:0] tag_page [SLOTS];
   logic [PID_W-1:0] tag_pid [SLOTS];
   bit               slot_valid [SLOTS];
   int unsigned      slot_rank [SLOTS];
   int unsigned      filled = 0;
   tlbl_cfg_type     cfg_shadow = '{policy_lru: 1'b0, page_shift: SHIFT_W'(12),
                                    entries_in_use: ENTRIES_W'(256), per_process: 1'b1};

   lookup_result_type pending_results[$];
   directed_row_type  directed_rows[$];
   logic [ADDR_W-1:0] page_pool [POOL_SIZE];
   int               mismatches = 0;
   int               results_taken = 0;
   int               burst_left [2] = '{0, 0};

   function automatic int unsigned eff_shift();
      if (cfg_shadow.page_shift < SHIFT_MIN) return SHIFT_MIN;
      if (cfg_shadow.page_shift > SHIFT_MAX) return SHIFT_MAX;
      return cfg_shadow.page_shift;
   endfunction

   function automatic int unsigned eff_capacity();
      if (cfg_shadow.entries_in_use == 0) return 1;
      if (cfg_shadow.entries_in_use > SLOTS) return SLOTS;
      return cfg_shadow.entries_in_use;
   endfunction

   function automatic lookup_result_type predict_lookup(input logic [ADDR_W-1:0] address,
                                                        input logic [PID_W-1:0] pid);
      logic [TAG_W-1:0]  page;
      int                found;
      int                slot;
      int                i;
      int unsigned       best;
      int unsigned       oldest;
      lookup_result_type res;
      page = TAG_W'(address >> eff_shift());
      found = -1;
      slot = -1;
      best = 0;
      res = '0;
      for (i = 0; i < SLOTS; i++) begin
         if (slot_valid[i] && tag_page[i] == page
             && (!cfg_shadow.per_process || tag_pid[i] == pid)
             && (found < 0 || slot_rank[i] < best)) begin
            found = i;
            best = slot_rank[i];
         end
      end
      if (found >= 0) begin
         res.hit = 1'b1;
         if (cfg_shadow.policy_lru) begin
            for (i = 0; i < SLOTS; i++)
               if (slot_valid[i] && slot_rank[i] < best) slot_rank[i]++;
            slot_rank[found] = 0;
         end
      end else begin
         if (filled >= eff_capacity() && filled > 0) begin
            oldest = filled - 1;
            for (i = 0; i < SLOTS; i++) begin
               if (!res.evicted && slot_valid[i] && slot_rank[i] == oldest) begin
                  slot_valid[i] = 1'b0;
                  res.evicted = 1'b1;
               end
            end
            if (res.evicted) filled--;
         end
         for (i = 0; i < SLOTS; i++) begin
            if (slot_valid[i]) slot_rank[i]++;
            else if (slot < 0) slot = i;
         end
         if (slot >= 0) begin
            tag_page[slot] = page;
            tag_pid[slot] = pid;
            slot_rank[slot] = 0;
            slot_valid[slot] = 1'b1;
            filled++;
         end
      end
      return res;
   endfunction

   function automatic int pick_gap(input int side);
      int roll;
      if (burst_left[side] > 0) begin
         burst_left[side]--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         burst_left[side] = $urandom_range(10, 40);
         return 0;
      end
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 700);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] with_spare_bits(input logic [CSR_DATA_W-1:0] value,
                                                             input int width);
      logic [CSR_DATA_W-1:0] keep;
      keep = (CSR_DATA_W'(1) << width) - 1'b1;
      return (CSR_DATA_W'($urandom) & ~keep) | (value & keep);
   endfunction

   function automatic directed_row_type lookup_row(input logic [ADDR_W-1:0] address,
                                                   input logic [PID_W-1:0] pid,
                                                   input bit typed = 1'b0,
                                                   input logic hit = 1'b0,
                                                   input logic evicted = 1'b0);
      directed_row_type row;
      row.is_csr = 1'b0;
      row.index = CSR_POLICY_LRU;
      row.data = '0;
      row.address = address;
      row.pid = pid;
      row.typed = typed;
      row.want.hit = hit;
      row.want.evicted = evicted;
      return row;
   endfunction

   function automatic directed_row_type csr_row(input logic [CSR_IDX_W-1:0] index,
                                                input logic [CSR_DATA_W-1:0] data);
      directed_row_type row;
      row = lookup_row('0, '0);
      row.is_csr = 1'b1;
      row.index = index;
      row.data = data;
      return row;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("tb: mismatch at result %0d: %s", results_taken, what);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data <= data;
      do @(posedge clock); while (!csr_ch.ready);
      case (index)
         CSR_POLICY_LRU:     cfg_shadow.policy_lru = data[0];
         CSR_PAGE_SHIFT:     cfg_shadow.page_shift = data[SHIFT_W-1:0];
         CSR_ENTRIES_IN_USE: cfg_shadow.entries_in_use = data[ENTRIES_W-1:0];
         CSR_PER_PROCESS:    cfg_shadow.per_process = data[0];
         default: ;
      endcase
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_lookup(input logic [ADDR_W-1:0] address, input logic [PID_W-1:0] pid,
                              input bit typed, input lookup_result_type want);
      int                gap;
      lookup_result_type predicted;
      gap = pick_gap(0);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.address <= address;
      req_ch.pid <= pid;
      do @(posedge clock); while (!req_ch.ready);
      predicted = predict_lookup(address, pid);
      pending_results.push_back(typed ? want : predicted);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int                phase;
      int                n;
      int                span;
      logic [ADDR_W-1:0] address;
      logic [ADDR_W-1:0] low_mask;
      logic [PID_W-1:0]  pid;
      logic [PID_W-1:0]  pid_pool [4];
      logic [CSR_DATA_W-1:0] shift_value;
      logic [CSR_DATA_W-1:0] entries_value;
      int                roll;

      req_ch.valid <= 1'b0;
      req_ch.address <= '0;
      req_ch.pid <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= CSR_POLICY_LRU;
      csr_ch.data <= '0;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;

      directed_rows.push_back(lookup_row(32'h0000_0000, 8'h00, 1, 0, 0));
      directed_rows.push_back(lookup_row(32'h0000_0FFF, 8'h00, 1, 1, 0));
      directed_rows.push_back(lookup_row(32'hFFFF_FFFF, 8'hFF, 1, 0, 0));
      directed_rows.push_back(lookup_row(32'hFFFF_F000, 8'hFF, 1, 1, 0));
      directed_rows.push_back(lookup_row(32'hFFFF_F000, 8'h00, 1, 0, 0));
      // global: two entries match, new entry keeps its pid
      directed_rows.push_back(csr_row(CSR_PER_PROCESS, 16'hFFFE));
      directed_rows.push_back(lookup_row(32'hFFFF_F123, 8'h5A, 1, 1, 0));
      directed_rows.push_back(lookup_row(32'h1234_5678, 8'h5A, 1, 0, 0));
      directed_rows.push_back(csr_row(CSR_PER_PROCESS, 16'h0001));
      directed_rows.push_back(lookup_row(32'h1234_5000, 8'h5A, 1, 1, 0));
      directed_rows.push_back(lookup_row(32'h1234_5000, 8'hA5, 1, 0, 0));
      // capacity written as zero (taken as one), far below occupancy
      directed_rows.push_back(csr_row(CSR_ENTRIES_IN_USE, 16'h0000));
      directed_rows.push_back(lookup_row(32'hAAAA_AAAA, 8'h55, 1, 0, 1));
      directed_rows.push_back(lookup_row(32'h5555_5555, 8'hAA, 1, 0, 1));
      directed_rows.push_back(csr_row(CSR_POLICY_LRU, 16'h0001));
      directed_rows.push_back(csr_row(CSR_PAGE_SHIFT, 16'hFFE0));
      directed_rows.push_back(csr_row(CSR_ENTRIES_IN_USE, 16'h01FF));
      directed_rows.push_back(csr_row(CSR_UNUSED, 16'hFFFF));
      directed_rows.push_back(lookup_row(32'h5555_5555, 8'hAA));
      directed_rows.push_back(lookup_row(32'h5555_555F, 8'hAA));
      directed_rows.push_back(lookup_row(32'hAAAA_AAAA, 8'h55));
      directed_rows.push_back(lookup_row(32'h5555_5550, 8'hAA));
      directed_rows.push_back(csr_row(CSR_PAGE_SHIFT, 16'h001F));
      directed_rows.push_back(csr_row(CSR_ENTRIES_IN_USE, 16'h0008));
      directed_rows.push_back(lookup_row(32'h0001_0000, 8'h01));
      directed_rows.push_back(lookup_row(32'h0001_FFFF, 8'h01));
      directed_rows.push_back(lookup_row(32'h0002_0000, 8'h01));
      directed_rows.push_back(csr_row(CSR_PAGE_SHIFT, 16'h0010));
      directed_rows.push_back(csr_row(CSR_POLICY_LRU, 16'h0000));
      directed_rows.push_back(lookup_row(32'h0001_8000, 8'h01));
      directed_rows.push_back(lookup_row(32'h8000_0000, 8'h80));
      directed_rows.push_back(csr_row(CSR_PAGE_SHIFT, 16'h0004));
      directed_rows.push_back(lookup_row(32'h0000_000F, 8'h00));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            drain_results();
            write_csr(directed_rows[i].index, directed_rows[i].data);
         end else begin
            send_lookup(directed_rows[i].address, directed_rows[i].pid,
                        directed_rows[i].typed, directed_rows[i].want);
         end
      end

      foreach (page_pool[i]) page_pool[i] = $urandom;
      pid_pool[0] = 8'h00;
      pid_pool[1] = 8'hFF;
      pid_pool[2] = PID_W'($urandom);
      pid_pool[3] = PID_W'($urandom);

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results();
         roll = $urandom_range(0, 99);
         shift_value = (roll < 85) ? CSR_DATA_W'($urandom_range(4, 16))
                                   : CSR_DATA_W'($urandom_range(0, 31));
         roll = $urandom_range(0, 99);
         if (roll < 55) entries_value = CSR_DATA_W'($urandom_range(8, 24));
         else if (roll < 75) entries_value = CSR_DATA_W'($urandom_range(25, 255));
         else if (roll < 88) entries_value = CSR_DATA_W'(SLOTS);
         else entries_value = CSR_DATA_W'($urandom_range(0, 511));
         write_csr(CSR_POLICY_LRU, with_spare_bits(CSR_DATA_W'($urandom_range(0, 1)), 1));
         write_csr(CSR_PAGE_SHIFT, with_spare_bits(shift_value, SHIFT_W));
         write_csr(CSR_ENTRIES_IN_USE, with_spare_bits(entries_value, ENTRIES_W));
         write_csr(CSR_PER_PROCESS, with_spare_bits(CSR_DATA_W'($urandom_range(0, 1)), 1));

         span = eff_capacity() + eff_capacity() / 4 + 2;
         if (span > POOL_SIZE) span = POOL_SIZE;
         low_mask = (ADDR_W'(1) << eff_shift()) - 1'b1;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 99) < 80)
               address = page_pool[$urandom_range(0, span - 1)] ^ (ADDR_W'($urandom) & low_mask);
            else
               address = $urandom;
            if ($urandom_range(0, 99) < 75) pid = pid_pool[$urandom_range(0, 3)];
            else pid = PID_W'($urandom);
            send_lookup(address, pid, 1'b0, '0);
         end
      end

      drain_results();
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : result_sink
      int gap;
      bit held;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && results_taken >= HOLD_OFF_AT) begin
            held = 1'b1;
            gap = HOLD_OFF_CYCLES;
         end else begin
            gap = pick_gap(1);
         end
         if (gap != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   always @(posedge clock) begin : result_check
      lookup_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_taken++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected item hit=%0b evicted=%0b",
                                      rsp_ch.hit, rsp_ch.evicted));
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.hit !== want.hit)
               report_mismatch($sformatf("hit %0b, want %0b", rsp_ch.hit, want.hit));
            if (rsp_ch.evicted !== want.evicted)
               report_mismatch($sformatf("evicted %0b, want %0b",
                                         rsp_ch.evicted, want.evicted));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int idle_cycles;
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

endmodule

`default_nettype wire
